@@ hw/rtl/fotl_pkg.sv @@
// ----------------------------------------------------------------------------
// fotl_pkg
// Shared types and constants for the focus-ordered tile list.
// ----------------------------------------------------------------------------
`default_nettype none

package fotl_pkg;

    localparam int MAX_WINDOWS = 16;
    localparam int ID_BITS     = 32;
    localparam int CNT_BITS    = $clog2(MAX_WINDOWS + 1);
    localparam int IDX_BITS    = $clog2(MAX_WINDOWS);

    localparam logic [2:0] REQ_INSERT  = 3'd0;
    localparam logic [2:0] REQ_REMOVE  = 3'd1;
    localparam logic [2:0] REQ_MOVE    = 3'd2;
    localparam logic [2:0] REQ_SETF    = 3'd3;
    localparam logic [2:0] REQ_COMPUTE = 3'd4;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_IGNORE = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    localparam logic [1:0] ADDR_VW  = 2'd0;
    localparam logic [1:0] ADDR_VH  = 2'd1;
    localparam logic [1:0] ADDR_GAP = 2'd2;

    // Operation applied by every cell of the chain in the same cycle.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_ROTATE
    } cell_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_STATUS,
        S_EMIT
    } state_t;

    // Control group broadcast to the cell row.
    typedef struct packed {
        cell_op_t            op;
        logic [IDX_BITS-1:0] pos;
        logic [ID_BITS-1:0]  id;
    } cell_ctl_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] window_id;
        logic [1:0]  direction;
    } in_beat_t;

    typedef struct packed {
        logic        is_placement;
        logic [1:0]  status;
        logic        focus_valid;
        logic [31:0] focused_window;
        logic [4:0]  window_count;
        logic [31:0] placed_window;
        logic signed [19:0] pos_x;
        logic [11:0] pos_y;
        logic [13:0] width_px;
        logic [13:0] height_px;
        logic        last;
    } out_beat_t;

endpackage

`default_nettype wire

@@ hw/rtl/fotl_cell.sv @@
// ----------------------------------------------------------------------------
// fotl_cell
// One slot of the window list; shifts with its neighbors on insert, remove
// and rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module fotl_cell (
    input  wire logic                          clk,
    input  wire fotl_pkg::cell_ctl_t           ctl,
    input  wire logic [fotl_pkg::IDX_BITS-1:0] my_idx,
    input  wire logic [fotl_pkg::ID_BITS-1:0]  left_id,
    input  wire logic [fotl_pkg::ID_BITS-1:0]  right_id,
    input  wire logic [fotl_pkg::ID_BITS-1:0]  wrap_id,
    input  wire logic                          is_tail,
    output logic      [fotl_pkg::ID_BITS-1:0]  id
);
    import fotl_pkg::*;

    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;

    always_comb
    begin
        id_next = id_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (my_idx == ctl.pos)
                    id_next = ctl.id;
                else if (my_idx > ctl.pos)
                    id_next = left_id;
            end
            OP_REMOVE:
            begin
                if (my_idx >= ctl.pos)
                    id_next = right_id;
            end
            // Rotate moves every entry one place toward the head; the head
            // entry comes round to the tail position through the wrap tap.
            OP_ROTATE:
            begin
                if (is_tail)
                    id_next = wrap_id;
                else
                    id_next = right_id;
            end
            default: id_next = id_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fotl_chain.sv @@
// ----------------------------------------------------------------------------
// fotl_chain
// Row of list cells with a tap at the head and a tap at the selected position.
// ----------------------------------------------------------------------------
`default_nettype none

module fotl_chain (
    input  wire logic                          clk,
    input  wire fotl_pkg::cell_ctl_t           ctl,
    input  wire logic [fotl_pkg::IDX_BITS-1:0] tail_idx,
    output logic      [fotl_pkg::ID_BITS-1:0]  head_id,
    output logic      [fotl_pkg::ID_BITS-1:0]  sel_id
);
    import fotl_pkg::*;

    logic [ID_BITS-1:0] ids [MAX_WINDOWS];
    logic [ID_BITS-1:0] wrap;

    // The scan rotates the row count times; the entry at the head wraps to
    // the tail so the order is restored after a full turn.
    assign wrap = ids[0];

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOWS; g++)
        begin : g_cell
            logic [ID_BITS-1:0] lft;
            logic [ID_BITS-1:0] rgt;
            if (g == 0)
            begin : g_l0
                assign lft = '0;
            end
            else
            begin : g_ln
                assign lft = ids[g-1];
            end
            if (g == MAX_WINDOWS - 1)
            begin : g_rn
                assign rgt = '0;
            end
            else
            begin : g_r
                assign rgt = ids[g+1];
            end
            fotl_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .my_idx   (IDX_BITS'(g)),
                .left_id  (lft),
                .right_id (rgt),
                .wrap_id  (wrap),
                .is_tail  (tail_idx == IDX_BITS'(g)),
                .id       (ids[g])
            );
        end
    endgenerate

    assign head_id = ids[0];
    assign sel_id  = ids[ctl.pos];

endmodule

`default_nettype wire

@@ hw/rtl/focus_ordered_tile_list.sv @@
// ----------------------------------------------------------------------------
// focus_ordered_tile_list
// Ordered window list with focus tracking and a tiled layout generator.
// ----------------------------------------------------------------------------
// Requests arrive as beats on the in channel (in_valid/in_stall, payload
// in_data). Results leave as beats on the out channel (out_valid/out_stall,
// payload out_data); a request gives one status beat, or one placement beat
// per window for a compute on a non-empty list, the final beat marked last.
// Viewport width, height and gap sit in an APB register file at byte
// addresses 0, 4 and 8; write them only while the block is idle.
// One request is handled at a time. Each request first rotates the row of
// list cells once around to find the first match of the request id and the
// focused id, then applies the request (an insert or remove shifts the row)
// and emits. A compute gives one placement beat per cycle while out_stall is
// low. A remove of the focused entry picks the new focus via sel_id before
// its status beat. The next request is accepted only after the final result
// beat has been taken (in_stall stays high until then).
// Reset clears count and focus; list slots hold garbage until written and
// are never read beyond the count. A stalled out beat holds in the output
// register and the block waits; in_stall is high while a request is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module focus_ordered_tile_list (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire fotl_pkg::in_beat_t in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output fotl_pkg::out_beat_t     out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);
    import fotl_pkg::*;

    // Configuration registers.
    logic [13:0] vw_reg;
    logic [13:0] vh_reg;
    logic [11:0] gap_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vw_reg  <= 14'd1920;
            vh_reg  <= 14'd1080;
            gap_reg <= 12'd8;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                ADDR_VW:  vw_reg  <= pwdata[13:0];
                ADDR_VH:  vh_reg  <= pwdata[13:0];
                ADDR_GAP: gap_reg <= pwdata[11:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            ADDR_VW:  prdata = {18'd0, vw_reg};
            ADDR_VH:  prdata = {18'd0, vh_reg};
            ADDR_GAP: prdata = {20'd0, gap_reg};
            default:  prdata = '0;
        endcase
    end

    // Layout constants, derived from the registers.
    logic signed [15:0] tw_raw;
    logic signed [15:0] th_raw;
    logic [13:0]        tile_w;
    logic [13:0]        tile_h;
    logic [14:0]        pitch;
    logic [13:0]        cen_x;

    assign tw_raw = $signed({2'b0, vw_reg}) - $signed({3'b0, gap_reg, 1'b0});
    assign th_raw = $signed({2'b0, vh_reg}) - $signed({3'b0, gap_reg, 1'b0});
    assign tile_w = (tw_raw < 16'sd1) ? 14'd1 : tw_raw[13:0];
    assign tile_h = (th_raw < 16'sd1) ? 14'd1 : th_raw[13:0];
    assign pitch  = {1'b0, tile_w} + {3'b0, gap_reg};
    // Only a zero viewport makes the tile wider than the viewport; the
    // half of that one-pixel deficit rounds to zero.
    assign cen_x  = (vw_reg == 14'd0) ? 14'd0 : 14'((vw_reg - tile_w) >> 1);

    // Control state.
    state_t               state_reg, state_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 fp_reg, fp_next;
    logic [ID_BITS-1:0]   fid_reg, fid_next;
    in_beat_t             req_reg, req_next;
    logic [CNT_BITS-1:0]  step_reg, step_next;
    logic [CNT_BITS-1:0]  hit_reg, hit_next;
    logic                 hitv_reg, hitv_next;
    logic [CNT_BITS-1:0]  fi_reg, fi_next;
    logic                 fiv_reg, fiv_next;
    logic [1:0]           st_reg, st_next;
    logic signed [21:0]   x_reg, x_next;
    logic                 ov_reg, ov_next;
    out_beat_t            ob_reg, ob_next;
    cell_ctl_t            ctl;
    logic [ID_BITS-1:0]   head_id;
    logic [ID_BITS-1:0]   sel_id;
    logic [IDX_BITS-1:0]  tail_idx;

    assign tail_idx = (cnt_reg == '0) ? '0 : IDX_BITS'(cnt_reg - 1'b1);

    fotl_chain u_chain (
        .clk      (clk),
        .ctl      (ctl),
        .tail_idx (tail_idx),
        .head_id  (head_id),
        .sel_id   (sel_id)
    );

    assign in_stall = (state_reg != S_IDLE) || ov_reg;

    always_comb
    begin
        logic [CNT_BITS-1:0] nidx;
        logic                fmatch;
        logic [CNT_BITS-1:0] pos;
        logic signed [21:0]  sx;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fp_next    = fp_reg;
        fid_next   = fid_reg;
        req_next   = req_reg;
        step_next  = step_reg;
        hit_next   = hit_reg;
        hitv_next  = hitv_reg;
        fi_next    = fi_reg;
        fiv_next   = fiv_reg;
        st_next    = st_reg;
        x_next     = x_reg;
        ov_next    = ov_reg && out_stall;
        ob_next    = ob_reg;
        ctl.op     = OP_HOLD;
        ctl.pos    = '0;
        ctl.id     = '0;
        nidx       = '0;
        fmatch     = 1'b0;
        pos        = '0;
        sx         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    req_next   = in_data;
                    step_next  = '0;
                    hitv_next  = 1'b0;
                    fiv_next   = 1'b0;
                    hit_next   = '0;
                    fi_next    = '0;
                    state_next = (cnt_reg == '0) ? S_APPLY : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // The head cell shows entry step; note the first matches.
                if (!hitv_reg && head_id == req_reg.window_id)
                begin
                    hitv_next = 1'b1;
                    hit_next  = step_reg;
                end
                if (fp_reg && !fiv_reg && head_id == fid_reg)
                begin
                    fiv_next = 1'b1;
                    fi_next  = step_reg;
                end
                ctl.op    = OP_ROTATE;
                step_next = step_reg + 1'b1;
                if (step_reg + 1'b1 == cnt_reg)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                st_next    = ST_IGNORE;
                state_next = S_STATUS;
                case (req_reg.req_type)
                    REQ_INSERT:
                    begin
                        if (cnt_reg >= CNT_BITS'(MAX_WINDOWS))
                            st_next = ST_FULL;
                        else
                        begin
                            pos      = fiv_reg ? fi_reg + 1'b1 : cnt_reg;
                            ctl.op   = OP_INSERT;
                            ctl.pos  = IDX_BITS'(pos);
                            ctl.id   = req_reg.window_id;
                            cnt_next = cnt_reg + 1'b1;
                            fp_next  = 1'b1;
                            fid_next = req_reg.window_id;
                            st_next  = ST_DONE;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (hitv_reg)
                        begin
                            ctl.op   = OP_REMOVE;
                            ctl.pos  = IDX_BITS'(hit_reg);
                            cnt_next = cnt_reg - 1'b1;
                            st_next  = ST_DONE;
                            if (cnt_reg == CNT_BITS'(1))
                            begin
                                fp_next  = 1'b0;
                                fid_next = '0;
                            end
                            else if (fp_reg && fid_reg == req_reg.window_id)
                                state_next = S_SCAN; // refocus, see below
                        end
                    end
                    REQ_MOVE:
                    begin
                        if (fiv_reg)
                        begin
                            nidx = fi_reg;
                            if (req_reg.direction == DIR_LEFT && fi_reg != '0)
                                nidx = fi_reg - 1'b1;
                            else if (req_reg.direction == DIR_RIGHT &&
                                     fi_reg + 1'b1 < cnt_reg)
                                nidx = fi_reg + 1'b1;
                            ctl.pos  = IDX_BITS'(nidx);
                            fid_next = sel_id;
                            st_next  = ST_DONE;
                        end
                    end
                    REQ_SETF:
                    begin
                        if (hitv_reg)
                        begin
                            fp_next  = 1'b1;
                            fid_next = req_reg.window_id;
                            st_next  = ST_DONE;
                        end
                    end
                    REQ_COMPUTE:
                    begin
                        if (cnt_reg == '0)
                            st_next = ST_EMPTY;
                        else
                        begin
                            fmatch     = fiv_reg;
                            step_next  = '0;
                            x_next     = $signed({8'd0, cen_x}) -
                                         $signed({2'd0, fmatch ? fi_reg :
                                                  {CNT_BITS{1'b0}}}) *
                                         $signed({7'd0, pitch});
                            state_next = S_EMIT;
                        end
                    end
                    default: st_next = ST_IGNORE;
                endcase
                // A removed focused entry: take the new entry at the hole,
                // clamped to the new tail. Picked next cycle via sel_id.
                if (state_next == S_SCAN)
                begin
                    state_next = S_STATUS;
                    req_next.req_type = REQ_MOVE;
                    hit_next = (hit_reg < cnt_reg - 1'b1) ? hit_reg :
                               cnt_reg - 2'd2;
                    hitv_next = 1'b1;
                    fiv_next  = 1'b0;
                end
            end
            S_STATUS:
            begin
                if (hitv_reg && !fiv_reg && req_reg.req_type == REQ_MOVE)
                begin
                    // Pending refocus after a remove.
                    ctl.pos   = IDX_BITS'(hit_reg);
                    fid_next  = sel_id;
                    hitv_next = 1'b0;
                end
                else if (!ov_reg || !out_stall)
                begin
                    ov_next                = 1'b1;
                    ob_next                = '0;
                    ob_next.status         = st_reg;
                    ob_next.focus_valid    = fp_reg;
                    ob_next.focused_window = fp_reg ? fid_reg : '0;
                    ob_next.window_count   = 5'(cnt_reg);
                    ob_next.last           = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ctl.pos = IDX_BITS'(step_reg);
                    sx = x_reg;
                    if (sx > 22'sd524287)
                        sx = 22'sd524287;
                    else if (sx < -22'sd524288)
                        sx = -22'sd524288;
                    ov_next                = 1'b1;
                    ob_next.is_placement   = 1'b1;
                    ob_next.status         = ST_DONE;
                    ob_next.focus_valid    = fp_reg;
                    ob_next.focused_window = fp_reg ? fid_reg : '0;
                    ob_next.window_count   = 5'(cnt_reg);
                    ob_next.placed_window  = sel_id;
                    ob_next.pos_x          = sx[19:0];
                    ob_next.pos_y          = gap_reg;
                    ob_next.width_px       = tile_w;
                    ob_next.height_px      = tile_h;
                    ob_next.last           = (step_reg + 1'b1 == cnt_reg);
                    x_next    = x_reg + $signed({7'd0, pitch});
                    step_next = step_reg + 1'b1;
                    if (step_reg + 1'b1 == cnt_reg)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            fp_reg    <= 1'b0;
            fid_reg   <= '0;
            ov_reg    <= 1'b0;
            hitv_reg  <= 1'b0;
            fiv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            fp_reg    <= fp_next;
            fid_reg   <= fid_next;
            ov_reg    <= ov_next;
            hitv_reg  <= hitv_next;
            fiv_reg   <= fiv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        step_reg <= step_next;
        hit_reg  <= hit_next;
        fi_reg   <= fi_next;
        st_reg   <= st_next;
        x_reg    <= x_next;
        ob_reg   <= ob_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = ob_reg;

    // The list never holds more entries than the row has cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(MAX_WINDOWS))
        else $error("window count above capacity");

    // An empty list has nothing focused once the request has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && cnt_reg == '0) |-> !fp_reg)
        else $error("focus held on an empty list");

    // A stalled output beat stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("output beat changed under stall");

endmodule

`default_nettype wire

@@ tb/sv/focus_ordered_tile_list_tb.sv @@
// ----------------------------------------------------------------------------
// focus_ordered_tile_list_tb
// Self-checking testbench for the focus-ordered tile list. Request beats are
// driven with random gaps, and the testbench predicts every status and
// placement beat from its own copy of the list, focus and layout registers.
// Result beats are stalled at random and compared; mismatches print per field.
// ----------------------------------------------------------------------------
`default_nettype none

module focus_ordered_tile_list_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fotl_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_CYCLES = 64;
    localparam logic [3:0] ADDR_VW_B  = 4'(ADDR_VW) << 2;
    localparam logic [3:0] ADDR_VH_B  = 4'(ADDR_VH) << 2;
    localparam logic [3:0] ADDR_GAP_B = 4'(ADDR_GAP) << 2;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_beat_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_beat_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    focus_ordered_tile_list i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the block's state, updated as each request beat is sent.
    logic [31:0] win_list [MAX_WINDOWS];
    int          win_count;
    logic        focus_on;
    logic [31:0] focus_win;
    int          vp_width;
    int          vp_height;
    int          gap_px;

    out_beat_t   expected_beats[$];
    int          error_count;
    longint      cycle_count;
    bit          idle_enable;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The run is ended by a cycle limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL focus_ordered_tile_list");
            $finish;
        end
    end

    // The receiver stalls at random while idling is enabled.
    always @(posedge clk)
    begin
        out_stall <= idle_enable && ($urandom_range(99) < 21);
    end

    // Every accepted result beat is compared with the oldest expectation.
    always @(posedge clk)
    begin
        out_beat_t exp_beat;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result beat %h", $time, out_data);
            end
            else
            begin
                exp_beat = expected_beats.pop_front();
                if (out_data !== exp_beat)
                begin
                    error_count++;
                    $display("%0t: mismatch expected %h actual %h", $time, exp_beat, out_data);
                    $display("  plc %b/%b st %0d/%0d fv %b/%b fw %h/%h cnt %0d/%0d",
                             exp_beat.is_placement, out_data.is_placement,
                             exp_beat.status, out_data.status,
                             exp_beat.focus_valid, out_data.focus_valid,
                             exp_beat.focused_window, out_data.focused_window,
                             exp_beat.window_count, out_data.window_count);
                    $display("  id %h/%h x %0d/%0d y %0d/%0d tw %0d/%0d th %0d/%0d last %b/%b",
                             exp_beat.placed_window, out_data.placed_window,
                             exp_beat.pos_x, out_data.pos_x,
                             exp_beat.pos_y, out_data.pos_y,
                             exp_beat.width_px, out_data.width_px,
                             exp_beat.height_px, out_data.height_px,
                             exp_beat.last, out_data.last);
                end
            end
        end
    end

    function automatic int find_window(logic [31:0] id);
        for (int i = 0; i < win_count; i++)
        begin
            if (win_list[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic int focus_slot();
        if (!focus_on)
            return -1;
        return find_window(focus_win);
    endfunction

    function automatic out_beat_t status_beat(logic [1:0] st);
        out_beat_t b;
        b = '0;
        b.status = st;
        b.focus_valid = focus_on;
        b.focused_window = focus_on ? focus_win : 32'd0;
        b.window_count = 5'(win_count);
        b.last = 1'b1;
        return b;
    endfunction

    // Applies one request to the shadow state and queues the beats it causes.
    task automatic predict_request(in_beat_t req);
        logic [1:0] st;
        int         idx;
        int         pos;
        longint     tw;
        longint     th;
        longint     pitch;
        longint     cx;
        longint     xpos;
        out_beat_t  b;
        st = ST_IGNORE;
        case (req.req_type)
            REQ_INSERT:
            begin
                if (win_count >= MAX_WINDOWS)
                    st = ST_FULL;
                else
                begin
                    idx = focus_slot();
                    pos = (idx < 0) ? win_count : idx + 1;
                    for (int i = win_count; i > pos; i--)
                        win_list[i] = win_list[i - 1];
                    win_list[pos] = req.window_id;
                    win_count++;
                    focus_on = 1'b1;
                    focus_win = req.window_id;
                    st = ST_DONE;
                end
            end
            REQ_REMOVE:
            begin
                idx = find_window(req.window_id);
                if (idx >= 0)
                begin
                    for (int i = idx; i + 1 < win_count; i++)
                        win_list[i] = win_list[i + 1];
                    win_count--;
                    if (win_count == 0)
                    begin
                        focus_on = 1'b0;
                        focus_win = '0;
                    end
                    else if (focus_on && focus_win == req.window_id)
                        focus_win = win_list[(idx < win_count) ? idx : win_count - 1];
                    st = ST_DONE;
                end
            end
            REQ_MOVE:
            begin
                idx = focus_slot();
                if (idx >= 0)
                begin
                    if (req.direction == DIR_LEFT && idx > 0)
                        idx--;
                    else if (req.direction == DIR_RIGHT && idx + 1 < win_count)
                        idx++;
                    focus_win = win_list[idx];
                    st = ST_DONE;
                end
            end
            REQ_SETF:
            begin
                if (find_window(req.window_id) >= 0)
                begin
                    focus_on = 1'b1;
                    focus_win = req.window_id;
                    st = ST_DONE;
                end
            end
            REQ_COMPUTE:
            begin
                if (win_count == 0)
                    st = ST_EMPTY;
                else
                begin
                    tw = vp_width - 2 * gap_px;
                    th = vp_height - 2 * gap_px;
                    if (tw < 1)
                        tw = 1;
                    if (th < 1)
                        th = 1;
                    pitch = tw + gap_px;
                    cx = vp_width - tw;
                    cx = (cx >= 0) ? cx / 2 : -((-cx) / 2);
                    idx = focus_slot();
                    if (idx < 0)
                        idx = 0;
                    for (int i = 0; i < win_count; i++)
                    begin
                        xpos = cx + longint'(i - idx) * pitch;
                        if (xpos > 524287)
                            xpos = 524287;
                        if (xpos < -524288)
                            xpos = -524288;
                        b = status_beat(ST_DONE);
                        b.is_placement = 1'b1;
                        b.placed_window = win_list[i];
                        b.pos_x = 20'(xpos);
                        b.pos_y = 12'(gap_px);
                        b.width_px = 14'(tw);
                        b.height_px = 14'(th);
                        b.last = (i + 1 == win_count);
                        expected_beats = {expected_beats, b};
                    end
                    return;
                end
            end
            default:
                st = ST_IGNORE;
        endcase
        expected_beats = {expected_beats, status_beat(st)};
    endtask

    // Sends one request beat, with an optional random gap before it.
    task automatic send_request(logic [2:0] rt, logic [31:0] id, logic [1:0] dir);
        in_beat_t req;
        while (idle_enable && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        req.req_type = rt;
        req.window_id = id;
        req.direction = dir;
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(req);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every expected beat has arrived and the block has settled.
    task automatic wait_drained();
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [3:0] addr, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_VW_B)
            vp_width = int'(value[13:0]);
        else if (addr == ADDR_VH_B)
            vp_height = int'(value[13:0]);
        else if (addr == ADDR_GAP_B)
            gap_px = int'(value[11:0]);
        @(posedge clk);
    endtask

    task automatic set_layout(int w, int h, int g);
        wait_drained();
        write_reg(ADDR_VW_B, 32'(w));
        write_reg(ADDR_VH_B, 32'(h));
        write_reg(ADDR_GAP_B, 32'(g));
    endtask

    // Directed checks of the list management corner cases.
    task automatic test_list_edges();
        send_request(REQ_COMPUTE, 32'd0, 2'd0);
        send_request(REQ_MOVE, 32'd0, DIR_LEFT);
        send_request(REQ_REMOVE, 32'h1234, 2'd0);
        send_request(REQ_SETF, 32'h1234, 2'd0);
        send_request(3'd5, 32'hFFFF_FFFF, 2'd3);
        send_request(3'd7, 32'd0, 2'd0);
        send_request(REQ_INSERT, 32'h0000_0000, 2'd0);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 2'd3);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 2'd2);
        send_request(REQ_MOVE, 32'd0, DIR_LEFT);
        send_request(REQ_MOVE, 32'd0, DIR_LEFT);
        send_request(REQ_MOVE, 32'd0, DIR_LEFT);
        send_request(REQ_MOVE, 32'd0, DIR_RIGHT);
        send_request(REQ_MOVE, 32'd0, 2'd2);
        send_request(REQ_SETF, 32'hFFFF_FFFF, 2'd0);
        send_request(REQ_COMPUTE, 32'd0, 2'd0);
        // Removing the focused entry hands focus to the entry that fills the hole.
        send_request(REQ_REMOVE, 32'hFFFF_FFFF, 2'd0);
        send_request(REQ_REMOVE, 32'h0000_0000, 2'd0);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF, 2'd0);
        // Fill to the limit and try one insert too many.
        for (int i = 0; i <= MAX_WINDOWS; i++)
            send_request(REQ_INSERT, 32'h100 + i, 2'd0);
        send_request(REQ_COMPUTE, 32'd0, 2'd0);
    endtask

    // Layout extremes on a full list, including tile sizes clamped to one pixel.
    task automatic test_layout_extremes();
        send_request(REQ_SETF, 32'h100, 2'd0);
        set_layout(0, 0, 0);
        send_request(REQ_COMPUTE, 32'd0, 2'd0);
        set_layout(16383, 16383, 4095);
        send_request(REQ_COMPUTE, 32'd0, 2'd0);
        set_layout(16383, 1, 0);
        send_request(REQ_COMPUTE, 32'd0, 2'd0);
        send_request(REQ_SETF, 32'h10F, 2'd0);
        send_request(REQ_COMPUTE, 32'd0, 2'd0);
        set_layout(100, 16383, 4095);
        send_request(REQ_COMPUTE, 32'd0, 2'd0);
        set_layout(1920, 1080, 8);
    endtask

    function automatic logic [31:0] pick_id();
        if ($urandom_range(3) == 0)
            return $urandom();
        return 32'($urandom_range(7));
    endfunction

    // Random traffic over a small id pool so that matches and duplicates occur.
    task automatic test_random_traffic(int n_items);
        int          kind;
        logic [31:0] id;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 60 == 59)
                set_layout($urandom_range(16383), $urandom_range(16383),
                           $urandom_range(3) == 0 ? $urandom_range(4095) : $urandom_range(64));
            idle_enable = !(k >= 150 && k < 220);
            kind = $urandom_range(99);
            id = (win_count > 0 && $urandom_range(1)) ?
                 win_list[$urandom_range(win_count - 1)] : pick_id();
            if (kind < 30)
                send_request(REQ_INSERT, id, 2'($urandom_range(3)));
            else if (kind < 50)
                send_request(REQ_REMOVE, id, 2'($urandom_range(3)));
            else if (kind < 65)
                send_request(REQ_MOVE, $urandom(), 2'($urandom_range(3)));
            else if (kind < 75)
                send_request(REQ_SETF, id, 2'($urandom_range(3)));
            else if (kind < 97)
                send_request(REQ_COMPUTE, $urandom(), 2'($urandom_range(3)));
            else
                send_request(3'($urandom_range(7, 5)), $urandom(), 2'($urandom_range(3)));
        end
        idle_enable = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycle_count = 0;
        error_count = 0;
        idle_enable = 1'b1;
        win_count = 0;
        focus_on = 1'b0;
        focus_win = '0;
        vp_width = 1920;
        vp_height = 1080;
        gap_px = 8;
        for (int i = 0; i < MAX_WINDOWS; i++)
            win_list[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_list_edges();
        test_layout_extremes();
        test_random_traffic(335);

        wait_drained();
        if (error_count == 0)
            $display("PASS focus_ordered_tile_list");
        else
            $display("FAIL focus_ordered_tile_list");
        $finish;
    end

endmodule

`default_nettype wire
